>>> sv/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// shared types and constants of the camera frame bundler with imu gate
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int unsigned MaxCameras = 4;
  localparam int unsigned SlotCount  = 8;
  localparam int unsigned MaxImus    = 4;

  localparam int unsigned StampW  = 63;
  localparam int unsigned HandleW = 32;
  localparam int unsigned SlotW   = $clog2(SlotCount);
  localparam int unsigned CamW    = 2;
  localparam int unsigned ImuW    = 2;
  localparam int unsigned CntW    = $clog2(SlotCount + 1);

  localparam int unsigned InDataW  = 232;
  localparam int unsigned OutDataW = 224;

  localparam logic [31:0] TolReset = 32'd2000000;

  typedef enum logic [1:0] {
    CFG_CAMERA_COUNT = 2'd0,
    CFG_IMU_COUNT    = 2'd1,
    CFG_SKIP_COUNT   = 2'd2,
    CFG_TOLERANCE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_STORE,
    ST_COUNT,
    ST_CHECK,
    ST_GATHER,
    ST_FILL,
    ST_GATE,
    ST_EMIT,
    ST_FREE
  } state_e;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic alloc_step;
    logic store;
    logic count_step;
    logic gather_step;
    logic set_pending;
    logic clr_pending;
    logic imu_write;
    logic skip_inc;
    logic emit_clr;
    logic emit;
    logic free_step;
    logic release_done;
  } cmd_t;

  typedef struct packed {
    logic is_frame;
    logic skip_active;
    logic cam_bad;
    logic cc_bad;
    logic idx_last;
    logic count_ok;
    logic filled_ok;
    logic pending;
    logic gate_ok;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

>>> sv/camera_frame_bundler_imu_gate.sv
// ----------------------------------------------------------------------------
// camera_frame_bundler_imu_gate
// groups camera frames into time-aligned bundles released under imu coverage
// ----------------------------------------------------------------------------
// One request is taken at a time. A frame makes up to three passes over the 8 slots,
// one slot a cycle, on one stamp subtractor and comparator; a released bundle
// then sends its members one by one and makes one more pass to free its slots.
// Results leave through an output register, so a new request is taken while
// the last result still waits.
module camera_frame_bundler_imu_gate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // stamp, camera_index, frame_handle, imu_index, imu_oldest_stamp,
  // imu_newest_stamp, imu_has_data, zero pad
  input  logic [cfb_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_camera, out_frame_stamp, out_handle, window_start, window_end, from_oldest
  output logic [cfb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import cfb_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_e state;
  logic   in_accept;

  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  cfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  cfb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state != ST_IDLE |-> !s_axis_tready) else $error("request taken while busy");
  a_take_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state == ST_DECODE) else $error("request not decoded");
  a_emit_from_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state == ST_EMIT) |-> $past(state) == ST_GATE) else $error("bad release entry");
`endif

endmodule

>>> sv/cfb_ctrl.sv
// ----------------------------------------------------------------------------
// cfb_ctrl
// sequencer for slot allocation, bundle matching, gating and release
// ----------------------------------------------------------------------------
module cfb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_accept_i,
  output logic            in_ready_o,
  input  cfb_pkg::sts_t   sts_i,
  output cfb_pkg::cmd_t   cmd_o,
  output cfb_pkg::state_e state_o
);
  import cfb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_accept_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (!sts_i.is_frame) state_d = ST_GATE;
        else if (sts_i.skip_active || sts_i.cam_bad) state_d = ST_IDLE;
        else state_d = ST_ALLOC;
      end
      ST_ALLOC:  if (sts_i.idx_last) state_d = ST_STORE;
      ST_STORE:  state_d = sts_i.cc_bad ? ST_IDLE : ST_COUNT;
      ST_COUNT:  if (sts_i.idx_last) state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.count_ok ? ST_GATHER : ST_IDLE;
      ST_GATHER: if (sts_i.idx_last) state_d = ST_FILL;
      ST_FILL:   state_d = sts_i.filled_ok ? ST_GATE : ST_IDLE;
      ST_GATE:   state_d = (sts_i.pending && sts_i.gate_ok) ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (sts_i.out_free && sts_i.emit_last) state_d = ST_FREE;
      ST_FREE:   if (sts_i.idx_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_accept_i;
      end
      ST_DECODE: begin
        cmd_o.imu_write = !sts_i.is_frame;
        cmd_o.skip_inc  = sts_i.is_frame && sts_i.skip_active;
        cmd_o.idx_clr   = 1'b1;
      end
      ST_ALLOC:  cmd_o.alloc_step = 1'b1;
      ST_STORE: begin
        cmd_o.store   = 1'b1;
        cmd_o.idx_clr = 1'b1;
      end
      ST_COUNT:  cmd_o.count_step = 1'b1;
      ST_CHECK:  cmd_o.idx_clr = 1'b1;
      ST_GATHER: cmd_o.gather_step = 1'b1;
      ST_FILL: begin
        cmd_o.set_pending = sts_i.filled_ok;
        cmd_o.clr_pending = !sts_i.filled_ok;
      end
      ST_GATE:   cmd_o.emit_clr = 1'b1;
      ST_EMIT: begin
        cmd_o.emit    = sts_i.out_free;
        cmd_o.idx_clr = 1'b1;
      end
      ST_FREE: begin
        cmd_o.free_step    = 1'b1;
        cmd_o.release_done = sts_i.idx_last;
      end
      default: cmd_o = '0;
    endcase
  end

  assign state_o = state_q;

endmodule

>>> sv/cfb_dp.sv
// ----------------------------------------------------------------------------
// cfb_dp
// slot store, bundle members, imu status, configuration and output register
// ----------------------------------------------------------------------------
module cfb_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfb_pkg::cmd_t                cmd_i,
  output cfb_pkg::sts_t                sts_o,
  input  logic                         in_op_i,
  input  logic [cfb_pkg::InDataW-1:0]  in_data_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cfb_pkg::OutDataW-1:0] out_data_o,
  output logic                         out_last_o
);
  import cfb_pkg::*;

  logic [2:0]  cam_cnt_q, imu_cnt_q;
  logic [15:0] skip_cnt_q, skipped_q;
  logic [31:0] tol_q;

  logic              op_q;
  logic [StampW-1:0] stamp_q, old_in_q, new_in_q;
  logic [CamW-1:0]   cam_q;
  logic [HandleW-1:0] handle_q;
  logic [ImuW-1:0]   imu_idx_q;
  logic              has_q;

  logic [SlotCount-1:0] slot_valid_q;
  logic [StampW-1:0]    slot_stamp_q [SlotCount];
  logic [CamW-1:0]      slot_cam_q   [SlotCount];
  logic [HandleW-1:0]   slot_handle_q[SlotCount];

  logic [SlotW-1:0]  idx_q;
  logic              found_q;
  logic [SlotW-1:0]  free_q, best_idx_q;
  logic [StampW-1:0] best_q;
  logic [CntW-1:0]   count_q;
  logic [MaxCameras-1:0] filled_q;

  logic              pending_q;
  logic [StampW-1:0] mem_stamp_q [MaxCameras];
  logic [HandleW-1:0] mem_handle_q[MaxCameras];
  logic              prior_valid_q;
  logic [StampW-1:0] prior_stamp_q;

  logic [MaxImus-1:0] imu_valid_q;
  logic [StampW-1:0]  imu_old_q[MaxImus];
  logic [StampW-1:0]  imu_new_q[MaxImus];

  logic [CamW-1:0] emit_idx_q;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic            out_last_q;

  logic [2:0]        imu_lim;
  logic [StampW-1:0] ref_stamp, diff;
  logic              near;
  logic              cur_valid;
  logic [SlotW-1:0]  sel_slot;
  logic              any_data, any_before, any_after, filled_ok;

  always_comb begin
    imu_lim   = (imu_cnt_q > 3'(MaxImus)) ? 3'(MaxImus) : imu_cnt_q;
    ref_stamp = cmd_i.free_step ? mem_stamp_q[0] : stamp_q;
    diff      = (ref_stamp > slot_stamp_q[idx_q]) ? ref_stamp - slot_stamp_q[idx_q]
                                                  : slot_stamp_q[idx_q] - ref_stamp;
    near      = diff < {31'd0, tol_q};
    cur_valid = slot_valid_q[idx_q];
    sel_slot  = found_q ? free_q : best_idx_q;
    any_data   = 1'b0;
    any_before = 1'b0;
    any_after  = 1'b0;
    for (int i = 0; i < MaxImus; i++) begin
      if (3'(i) < imu_lim) begin
        if (imu_valid_q[i]) any_data = 1'b1;
        if (imu_old_q[i] < mem_stamp_q[0]) any_before = 1'b1;
        if (imu_new_q[i] > mem_stamp_q[0]) any_after = 1'b1;
      end
    end
    filled_ok = 1'b1;
    for (int k = 0; k < MaxCameras; k++) begin
      if (3'(k) < cam_cnt_q && !filled_q[k]) filled_ok = 1'b0;
    end
  end

  assign sts_o.is_frame    = !op_q;
  assign sts_o.skip_active = skipped_q < skip_cnt_q;
  assign sts_o.cam_bad     = {1'b0, cam_q} >= cam_cnt_q;
  assign sts_o.cc_bad      = (cam_cnt_q == 3'd0) || (cam_cnt_q > 3'(MaxCameras));
  assign sts_o.idx_last    = idx_q == SlotW'(SlotCount - 1);
  assign sts_o.count_ok    = count_q == CntW'(cam_cnt_q);
  assign sts_o.filled_ok   = filled_ok;
  assign sts_o.pending     = pending_q;
  assign sts_o.gate_ok     = (imu_lim == 3'd0) || (any_data && any_before && any_after);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.emit_last   = ({1'b0, emit_idx_q} + 3'd1) == cam_cnt_q;

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_cnt_q     <= 3'd1;
      imu_cnt_q     <= 3'd0;
      skip_cnt_q    <= '0;
      tol_q         <= TolReset;
      skipped_q     <= '0;
      slot_valid_q  <= '0;
      pending_q     <= 1'b0;
      prior_valid_q <= 1'b0;
      prior_stamp_q <= '0;
      imu_valid_q   <= '0;
      out_valid_q   <= 1'b0;
      op_q          <= 1'b0;
      idx_q         <= '0;
      emit_idx_q    <= '0;
      for (int i = 0; i < MaxImus; i++) begin
        imu_old_q[i] <= '0;
        imu_new_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CAMERA_COUNT: cam_cnt_q  <= cfg_data_i[2:0];
          CFG_IMU_COUNT:    imu_cnt_q  <= cfg_data_i[2:0];
          CFG_SKIP_COUNT:   skip_cnt_q <= cfg_data_i[15:0];
          CFG_TOLERANCE:    tol_q      <= cfg_data_i;
          default:          ;
        endcase
      end
      if (cmd_i.load) op_q <= in_op_i;
      if (cmd_i.skip_inc && cam_q == '0) skipped_q <= skipped_q + 16'd1;
      if (cmd_i.imu_write && {1'b0, imu_idx_q} < imu_lim) begin
        imu_valid_q[imu_idx_q] <= has_q;
        imu_old_q[imu_idx_q]   <= old_in_q;
        imu_new_q[imu_idx_q]   <= new_in_q;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.alloc_step || cmd_i.count_step || cmd_i.gather_step || cmd_i.free_step)
        idx_q <= idx_q + SlotW'(1);
      if (cmd_i.store) slot_valid_q[sel_slot] <= 1'b1;
      if (cmd_i.free_step && cur_valid && near) slot_valid_q[idx_q] <= 1'b0;
      if (cmd_i.set_pending) pending_q <= 1'b1;
      if (cmd_i.clr_pending) pending_q <= 1'b0;
      if (cmd_i.release_done) begin
        pending_q     <= 1'b0;
        prior_valid_q <= 1'b1;
        prior_stamp_q <= mem_stamp_q[0];
      end
      if (cmd_i.emit_clr) emit_idx_q <= '0;
      else if (cmd_i.emit) emit_idx_q <= emit_idx_q + CamW'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stamp_q   <= in_data_i[62:0];
      cam_q     <= in_data_i[64:63];
      handle_q  <= in_data_i[96:65];
      imu_idx_q <= in_data_i[98:97];
      old_in_q  <= in_data_i[161:99];
      new_in_q  <= in_data_i[224:162];
      has_q     <= in_data_i[225];
    end
    if (cmd_i.alloc_step) begin
      if (idx_q == '0) begin
        found_q    <= !cur_valid;
        free_q     <= '0;
        best_q     <= slot_stamp_q[idx_q];
        best_idx_q <= '0;
      end else begin
        if (!cur_valid && !found_q) begin
          found_q <= 1'b1;
          free_q  <= idx_q;
        end
        if (slot_stamp_q[idx_q] < best_q) begin
          best_q     <= slot_stamp_q[idx_q];
          best_idx_q <= idx_q;
        end
      end
    end
    if (cmd_i.store) begin
      slot_stamp_q[sel_slot]  <= stamp_q;
      slot_cam_q[sel_slot]    <= cam_q;
      slot_handle_q[sel_slot] <= handle_q;
    end
    if (cmd_i.idx_clr) begin
      count_q  <= '0;
      filled_q <= '0;
    end
    if (cmd_i.count_step && cur_valid && near) count_q <= count_q + CntW'(1);
    if (cmd_i.gather_step && cur_valid && near
        && {1'b0, slot_cam_q[idx_q]} < cam_cnt_q) begin
      mem_stamp_q[slot_cam_q[idx_q]]  <= slot_stamp_q[idx_q];
      mem_handle_q[slot_cam_q[idx_q]] <= slot_handle_q[idx_q];
      filled_q[slot_cam_q[idx_q]]     <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_data_q <= {!prior_valid_q, mem_stamp_q[0],
                     prior_valid_q ? prior_stamp_q : {StampW{1'b0}},
                     mem_handle_q[emit_idx_q], mem_stamp_q[emit_idx_q], emit_idx_q};
      out_last_q <= ({1'b0, emit_idx_q} + 3'd1) == cam_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

>>> test/camera_frame_bundler_imu_gate_tb.sv
// ----------------------------------------------------------------------------
// camera_frame_bundler_imu_gate_tb
// drives frame and imu requests with random idling on both streams, predicts
// each released bundle member and checks every result against that prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module camera_frame_bundler_imu_gate_tb;
  import cfb_pkg::*;

  typedef struct packed {
    logic [1:0]  cam;
    logic [62:0] fstamp;
    logic [31:0] handle;
    logic [62:0] wstart;
    logic [62:0] wend;
    logic        oldest;
    logic        last;
  } member_t;

  class bundle_board;
    logic [2:0]  cam_cnt;
    logic [2:0]  imu_cnt;
    logic [15:0] skip_cnt;
    logic [31:0] tol;
    logic        sv_ok [SlotCount];
    logic [62:0] s_stamp [SlotCount];
    logic [1:0]  s_cam [SlotCount];
    logic [31:0] s_hdl [SlotCount];
    logic [15:0] skipped;
    logic        pending;
    logic [62:0] m_stamp [MaxCameras];
    logic [31:0] m_hdl [MaxCameras];
    logic        prior_ok;
    logic [62:0] prior_stamp;
    logic        imu_ok [MaxImus];
    logic [62:0] imu_old [MaxImus];
    logic [62:0] imu_new [MaxImus];
    member_t     awaited [$];
    int          errors;
    int          bundles;
    int          checked;

    function new();
      cam_cnt = 1; imu_cnt = 0; skip_cnt = 0; tol = TolReset;
      skipped = 0; pending = 0; prior_ok = 0; prior_stamp = 0;
      errors = 0; bundles = 0; checked = 0;
      foreach (sv_ok[i]) sv_ok[i] = 0;
      foreach (imu_ok[i]) begin
        imu_ok[i] = 0; imu_old[i] = 0; imu_new[i] = 0;
      end
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_CAMERA_COUNT: cam_cnt = v[2:0];
        CFG_IMU_COUNT:    imu_cnt = v[2:0];
        CFG_SKIP_COUNT:   skip_cnt = v[15:0];
        default:          tol = v;
      endcase
    endfunction

    function bit near(logic [62:0] a, logic [62:0] b);
      logic [62:0] d;
      d = (a > b) ? a - b : b - a;
      return d < {31'd0, tol};
    endfunction

    function int imu_lim();
      return (imu_cnt > MaxImus) ? MaxImus : imu_cnt;
    endfunction

    function void release_bundle();
      logic [62:0] bs;
      bit dat, bef, aft;
      if (!pending) return;
      bs = m_stamp[0];
      if (imu_lim() != 0) begin
        dat = 0; bef = 0; aft = 0;
        for (int i = 0; i < imu_lim(); i++) begin
          if (imu_ok[i]) dat = 1;
          if (imu_old[i] < bs) bef = 1;
          if (imu_new[i] > bs) aft = 1;
        end
        if (!(dat && bef && aft)) return;
      end
      for (int i = 0; i < cam_cnt; i++) begin
        member_t m;
        m.cam = i[1:0]; m.fstamp = m_stamp[i]; m.handle = m_hdl[i];
        m.wstart = prior_ok ? prior_stamp : '0; m.wend = bs;
        m.oldest = !prior_ok; m.last = (i + 1 == cam_cnt);
        awaited.insert(awaited.size(), m);
      end
      for (int i = 0; i < SlotCount; i++)
        if (sv_ok[i] && near(bs, s_stamp[i])) sv_ok[i] = 0;
      prior_ok = 1; prior_stamp = bs; pending = 0; bundles++;
    endfunction

    function void note_frame(logic [62:0] st, logic [1:0] c, logic [31:0] h);
      int sl, cnt;
      bit got;
      bit filled [MaxCameras];
      logic [62:0] best;
      if (skipped < skip_cnt) begin
        if (c == 0) skipped++;
        return;
      end
      if (c >= cam_cnt) return;
      got = 0; sl = 0;
      for (int i = 0; i < SlotCount; i++)
        if (!got && !sv_ok[i]) begin sl = i; got = 1; end
      if (!got) begin
        best = s_stamp[0];
        for (int i = 1; i < SlotCount; i++)
          if (s_stamp[i] < best) begin best = s_stamp[i]; sl = i; end
      end
      sv_ok[sl] = 1; s_stamp[sl] = st; s_cam[sl] = c; s_hdl[sl] = h;
      if (cam_cnt == 0 || cam_cnt > MaxCameras) return;
      cnt = 0;
      for (int i = 0; i < SlotCount; i++)
        if (sv_ok[i] && near(st, s_stamp[i])) cnt++;
      if (cnt != cam_cnt) return;
      foreach (filled[i]) filled[i] = 0;
      for (int i = 0; i < SlotCount; i++)
        if (sv_ok[i] && near(st, s_stamp[i]) && s_cam[i] < cam_cnt) begin
          m_stamp[s_cam[i]] = s_stamp[i]; m_hdl[s_cam[i]] = s_hdl[i];
          filled[s_cam[i]] = 1;
        end
      for (int i = 0; i < cam_cnt; i++)
        if (!filled[i]) begin pending = 0; return; end
      pending = 1;
      release_bundle();
    endfunction

    function void note_request(logic op, logic [InDataW-1:0] d);
      if (!op) note_frame(d[62:0], d[64:63], d[96:65]);
      else begin
        if (d[98:97] < imu_lim()) begin
          imu_old[d[98:97]] = d[161:99];
          imu_new[d[98:97]] = d[224:162];
          imu_ok[d[98:97]] = d[225];
        end
        release_bundle();
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] d, logic lst);
      member_t g, e;
      g = {d[1:0], d[64:2], d[96:65], d[159:97], d[222:160], d[223], lst};
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", g);
        return;
      end
      e = awaited.pop_front();
      if (g !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch exp %h got %h", e, g);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tuser = 0, m_axis_tready = 0;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, m_axis_tlast, cfg_ready_o;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 0;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  bundle_board board;
  int cycles = 0, sent = 0, limit_hit = 0;
  bit calm = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  camera_frame_bundler_imu_gate DUT (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk_i) if (cycles > 400000) begin
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic idle_gap();
    if (!calm) while ($urandom_range(99) < 26) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, v);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic push(logic op, logic [InDataW-1:0] d);
    idle_gap();
    s_axis_tvalid <= 1; s_axis_tuser <= op; s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 0;
    sent++;
    @(posedge clk_i);
  endtask

  // unused imu fields of a frame request carry noise
  task automatic frame(logic [62:0] st, logic [1:0] c, logic [31:0] h);
    logic [InDataW-1:0] d;
    d = InDataW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
    d[96:0] = {h, c, st};
    d[InDataW-1:226] = '0;
    push(1'b0, d);
  endtask

  // unused frame fields of an imu request carry noise
  task automatic imu(logic [1:0] i, logic [62:0] o, logic [62:0] n, logic hd);
    logic [InDataW-1:0] d;
    d = InDataW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
    d[225:97] = {hd, n, o, i};
    d[InDataW-1:226] = '0;
    push(1'b1, d);
  endtask

  task automatic drain();
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    logic [62:0] base;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: single camera, no gating, field extremes
    frame(63'd0, 2'd0, 32'd0);
    frame({63{1'b1}}, 2'd0, 32'hffffffff);
    frame(63'd1000, 2'd3, 32'h1);
    imu(2'd3, {63{1'b1}}, 63'd0, 1'b1);
    drain();
    write_reg(CFG_CAMERA_COUNT, 32'd4);
    write_reg(CFG_IMU_COUNT, 32'd2);
    write_reg(CFG_SKIP_COUNT, 32'd2);
    write_reg(CFG_TOLERANCE, 32'd500);
    frame(63'd10, 2'd1, 32'h11);
    frame(63'd20, 2'd0, 32'h12);
    frame(63'd30, 2'd0, 32'h13);
    // a full bundle held by the imu gate, with a second frame of one camera
    for (int c = 0; c < 4; c++) frame(63'd5000 + c, c[1:0], 32'h100 + c);
    frame(63'd5010, 2'd2, 32'h222);
    imu(2'd0, 63'd100, 63'd4000, 1'b1);
    imu(2'd1, 63'd100, 63'd9000, 1'b0);
    imu(2'd3, 63'd0, {63{1'b1}}, 1'b1);
    drain();
    write_reg(CFG_TOLERANCE, 32'd0);
    frame(63'd1, 2'd0, 32'h5);
    drain();
    write_reg(CFG_CAMERA_COUNT, 32'd7);
    write_reg(CFG_TOLERANCE, 32'hffffffff);
    frame(63'd77, 2'd0, 32'h6);
    drain();
    // random phases, well-formed bundles with noise
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      write_reg(CFG_CAMERA_COUNT, $urandom_range(4, 1));
      write_reg(CFG_IMU_COUNT, (ph == 5) ? 32'd4 : $urandom_range(4));
      write_reg(CFG_SKIP_COUNT, $urandom_range(1));
      write_reg(CFG_TOLERANCE, $urandom_range(3000, 50));
      base = {29'd0, 2'($urandom_range(3)), $urandom} + 63'd100000;
      for (int k = 0; k < 5; k++) begin
        base = base + $urandom_range(20000, 5000);
        if ($urandom_range(9) < 7) begin
          for (int c = 0; c < board.cam_cnt; c++)
            frame(base + $urandom_range(40), c[1:0], $urandom);
          for (int i = 0; i < board.imu_cnt && $urandom_range(3) != 0; i++)
            imu(i[1:0], base - $urandom_range(9000), base + $urandom_range(9000),
                $urandom_range(4) != 0);
        end else if ($urandom_range(1))
          frame(63'({$urandom, $urandom}), 2'($urandom_range(3)), $urandom);
        else
          imu(2'($urandom_range(3)), 63'({$urandom, $urandom}),
              63'({$urandom, $urandom}), 1'($urandom));
      end
      drain();
    end
    $display("sent %0d requests, released %0d bundles, checked %0d members",
             sent, board.bundles, board.checked);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
